// ----- src/scpc_pkg.sv -----
// Shared types, constants and functions of the span change palette classifier.
`default_nettype none

package scpc_pkg;

	// Sizes of the color map and the default span buffer depth.
	localparam int MAX_SPAN_DEF = 32;
	localparam int COLOR_W      = 16;
	localparam int MAP_DEPTH    = 65536;
	localparam int IDX_W        = 9;

	// Palette index boundaries.
	localparam logic [IDX_W-1:0] RAW_INDEX = 9'd276;
	localparam logic [IDX_W-1:0] P4_BASE   = 9'd4;
	localparam logic [IDX_W-1:0] P8_BASE   = 9'd20;

	// RGB565 field masks.
	localparam logic [15:0] MASK_R = 16'hf800;
	localparam logic [15:0] MASK_G = 16'h07e0;
	localparam logic [15:0] MASK_B = 16'h001f;

	// Request modes.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	// Result kinds.
	localparam logic KIND_SPAN   = 1'b0;
	localparam logic KIND_SYMBOL = 1'b1;

	// Palette class selectors and their symbol widths.
	localparam logic [1:0] SEL_P2  = 2'd0;
	localparam logic [1:0] SEL_P4  = 2'd1;
	localparam logic [1:0] SEL_P8  = 2'd2;
	localparam logic [1:0] SEL_RAW = 2'd3;

	localparam logic [4:0] BITS_P2  = 5'd2;
	localparam logic [4:0] BITS_P4  = 5'd4;
	localparam logic [4:0] BITS_P8  = 5'd8;
	localparam logic [4:0] BITS_RAW = 5'd16;

	// One input request.
	typedef struct packed {
		logic             mode;
		logic [15:0]      map_color;
		logic [IDX_W-1:0] map_index;
		logic [31:0]      current_pixel;
		logic [31:0]      previous_pixel;
		logic             span_end;
	} item_t;

	// One result.
	typedef struct packed {
		logic        kind;
		logic        span_diff;
		logic [1:0]  selector;
		logic [15:0] symbol;
		logic [4:0]  sym_width;
		logic        last;
	} result_t;

	// Reduce an ARGB8888 word (red in bits 23:16, green in 15:8, blue in 7:0) to RGB565.
	function automatic logic [15:0] rgb565(input logic [31:0] w);
		logic [31:0] r;
		logic [31:0] g;
		logic [31:0] b;
		r = w >> 8;
		g = w >> 5;
		b = w >> 3;
		return (r[15:0] & MASK_R) | (g[15:0] & MASK_G) | (b[15:0] & MASK_B);
	endfunction

	// Build a symbol result from a map entry and its color.
	function automatic result_t classify(input logic [IDX_W-1:0] idx,
		input logic [15:0] color, input logic last);
		result_t          res;
		logic [IDX_W-1:0] off;
		res.kind         = KIND_SYMBOL;
		res.span_diff    = 1'b0;
		res.last         = last;
		if (idx < P4_BASE) begin
			off           = idx;
			res.selector  = SEL_P2;
			res.symbol    = {{(16-IDX_W){1'b0}}, off};
			res.sym_width = BITS_P2;
		end else if (idx < P8_BASE) begin
			off           = idx - P4_BASE;
			res.selector  = SEL_P4;
			res.symbol    = {{(16-IDX_W){1'b0}}, off};
			res.sym_width = BITS_P4;
		end else if (idx < RAW_INDEX) begin
			off           = idx - P8_BASE;
			res.selector  = SEL_P8;
			res.symbol    = {{(16-IDX_W){1'b0}}, off};
			res.sym_width = BITS_P8;
		end else begin
			res.selector  = SEL_RAW;
			res.symbol    = color;
			res.sym_width = BITS_RAW;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- src/scpc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module scpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/span_change_palette_classifier_core.sv -----
// Top level of the span change palette classifier.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_ready    scpc_pkg::item_t
//   result    out        result_valid / result_ready scpc_pkg::result_t
//
// A map load or a pixel that leaves its span open keeps the core in idle.
// A closing pixel moves to the span head state, which sends the span change result;
// for a changed span a drain then sends one symbol per buffered pixel, with the span
// buffer read feeding the color map read in series, and returns to idle.
// After reset a clearing pass writes all 65536 map entries, one per cycle;
// item_ready stays low until the pass is over.
// A stalled result output freezes the whole read pipeline; nothing is dropped.
`default_nettype none

module span_change_palette_classifier_core #(
	parameter int MAX_SPAN = scpc_pkg::MAX_SPAN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire scpc_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output scpc_pkg::result_t      result
);

	localparam int FILL_W  = $clog2(MAX_SPAN + 1);
	localparam int SPAN_AW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
	localparam int MAP_AW  = $clog2(scpc_pkg::MAP_DEPTH);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_HEAD  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [MAP_AW-1:0]            clr_idx_q;
	logic [FILL_W-1:0]            fill_q;
	logic                         change_q;
	logic [FILL_W-1:0]            rd_idx_q;
	logic                         v_s1_q;
	logic                         v_s2_q;
	logic                         last_s1;
	logic                         last_s2;
	logic [15:0]                  color_s2;
	logic                         out_valid_q;
	scpc_pkg::result_t            out_q;

	logic                         accept;
	logic                         is_pixel;
	logic [15:0]                  cur_color;
	logic [15:0]                  prev_color;
	logic [FILL_W-1:0]            fill_inc;
	logic                         close;
	logic                         adv;
	logic                         issue;
	logic                         done;
	logic                         load_head;
	logic                         load_sym;
	logic [FILL_W-1:0]            rd_idx_inc;

	logic                         map_we;
	logic [MAP_AW-1:0]            map_waddr;
	logic [scpc_pkg::IDX_W-1:0]   map_wdata;
	logic [scpc_pkg::IDX_W-1:0]   map_rdata;
	logic [15:0]                  span_rdata;

	// Request acceptance and the pixel pair reduction.
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign is_pixel   = (item.mode == scpc_pkg::MODE_PIXEL);
	assign cur_color  = scpc_pkg::rgb565(item.current_pixel);
	assign prev_color = scpc_pkg::rgb565(item.previous_pixel);
	assign fill_inc   = fill_q + FILL_W'(1);
	assign close      = item.span_end || (fill_inc == FILL_W'(MAX_SPAN));

	// The read pipeline moves whenever the output register is free or being emptied.
	assign adv        = !out_valid_q || result_ready;
	assign issue      = (state_q == ST_DRAIN) && (rd_idx_q != fill_q);
	assign done       = (state_q == ST_DRAIN) && !issue && !v_s1_q && !v_s2_q;
	assign rd_idx_inc = rd_idx_q + FILL_W'(1);
	assign load_head  = (state_q == ST_HEAD) && adv;
	assign load_sym   = adv && v_s2_q;

	// Map write port is shared by the clearing pass and load requests.
	assign map_we    = (state_q == ST_CLEAR) || (accept && !is_pixel);
	assign map_waddr = (state_q == ST_CLEAR) ? clr_idx_q : item.map_color;
	assign map_wdata = (state_q == ST_CLEAR) ? scpc_pkg::RAW_INDEX : item.map_index;

	scpc_ram #(
		.WIDTH (scpc_pkg::IDX_W),
		.DEPTH (scpc_pkg::MAP_DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (map_we),
		.wr_addr (map_waddr),
		.wr_data (map_wdata),
		.rd_en   (adv && v_s1_q),
		.rd_addr (span_rdata),
		.rd_data (map_rdata)
	);

	scpc_ram #(
		.WIDTH (scpc_pkg::COLOR_W),
		.DEPTH (MAX_SPAN)
	) u_span (
		.clk     (clk),
		.wr_en   (accept && is_pixel),
		.wr_addr (fill_q[SPAN_AW-1:0]),
		.wr_data (cur_color),
		.rd_en   (adv && issue),
		.rd_addr (rd_idx_q[SPAN_AW-1:0]),
		.rd_data (span_rdata)
	);

	// Sequencer: clearing pass, span collection, span head and drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			fill_q    <= '0;
			change_q  <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + MAP_AW'(1);
					if (clr_idx_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_pixel) begin
						fill_q   <= fill_inc;
						change_q <= change_q || (cur_color != prev_color);
						if (close) begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					if (adv) begin
						rd_idx_q <= '0;
						if (change_q) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
						end
					end
				end
				ST_DRAIN: begin
					if (adv && issue) begin
						rd_idx_q <= rd_idx_inc;
					end
					if (done) begin
						state_q  <= ST_IDLE;
						fill_q   <= '0;
						change_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Valid flags of the two read stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else if (adv) begin
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
		end
	end

	// Payload of the two read stages.
	always_ff @(posedge clk) begin
		if (adv && issue) begin
			last_s1 <= (rd_idx_inc == fill_q);
		end
		if (adv && v_s1_q) begin
			last_s2  <= last_s1;
			color_s2 <= span_rdata;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_head || load_sym) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_head) begin
			out_q.kind      <= scpc_pkg::KIND_SPAN;
			out_q.span_diff <= change_q;
			out_q.selector  <= scpc_pkg::SEL_P2;
			out_q.symbol    <= '0;
			out_q.sym_width <= '0;
			out_q.last      <= !change_q;
		end else if (load_sym) begin
			out_q <= scpc_pkg::classify(map_rdata, color_s2, last_s2);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ----- src/scpc_checker.sv -----
// Port-level checker for the span change palette classifier, bound to the top level.
`default_nettype none

module scpc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_ready,
	input wire scpc_pkg::item_t   item,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire scpc_pkg::result_t result
);

	// A waiting result keeps its valid and its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// A pixel that closes its span stops further requests for the span head.
	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.mode == scpc_pkg::MODE_PIXEL && item.span_end
		|=> !item_ready)
		else $error("request taken while a span head is pending");

	// After a changed span head, symbols follow before new requests are taken.
	a_head_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result.kind == scpc_pkg::KIND_SPAN
		&& result.span_diff |=> !item_ready)
		else $error("request taken before span symbols were sent");

	// A symbol that is not the last one leaves the drain running.
	a_sym_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result.kind == scpc_pkg::KIND_SYMBOL
		&& !result.last |=> !item_ready)
		else $error("request taken in the middle of a span drain");

endmodule

bind span_change_palette_classifier_core scpc_checker u_scpc_checker (.*);

`default_nettype wire
